// ----- hw/rtl/point_in_cylinder_test_defines.svh -----
// assertion macros for the point-in-cylinder block
`ifndef POINT_IN_CYLINDER_TEST_DEFINES_SVH
`define POINT_IN_CYLINDER_TEST_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PIC_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define PIC_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hw/rtl/pic_pkg.sv -----
// shared widths, types and helpers for the point-in-cylinder block
`default_nettype none

package pic_pkg;

  // coordinate format
  localparam int COORD_W   = 20;
  localparam int RAD_W     = COORD_W - 1;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int HALF_W    = MAG_W / 2;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int AREA_W    = SQ_W + 2;
  localparam int LEN2_W    = PROD_W;
  localparam int LEN2_HALF = LEN2_W / 2;
  localparam int RAD2_W    = 2 * RAD_W;
  localparam int LPP_W     = RAD_W + LEN2_HALF;
  localparam int LIMIT_W   = RAD2_W + LEN2_W;

  // register file
  localparam int REG_N  = 7;
  localparam int IDX_W  = $clog2(REG_N);
  localparam int APB_AW = IDX_W + 2;
  localparam int APB_DW = 32;

  localparam logic [COORD_W-1:0] TOP_Z_RESET = COORD_W'(256);
  localparam logic [RAD_W-1:0]   RAD_RESET   = RAD_W'(256);

  // cycles for the geometry chain to follow the registers
  localparam int SETTLE_CYC = 5;
  localparam int SETTLE_W   = $clog2(SETTLE_CYC + 1);

  // item pipeline depth, output register included
  localparam int STG_N = 8;

  typedef enum logic [IDX_W-1:0] {
    REG_BOTTOM_X = IDX_W'(0),
    REG_BOTTOM_Y = IDX_W'(1),
    REG_BOTTOM_Z = IDX_W'(2),
    REG_TOP_X    = IDX_W'(3),
    REG_TOP_Y    = IDX_W'(4),
    REG_TOP_Z    = IDX_W'(5),
    REG_RADIUS   = IDX_W'(6)
  } pic_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } pic_in_t;

  typedef struct packed {
    logic is_inside;
    logic axis_degenerate;
  } pic_out_t;

  // cylinder geometry derived from the registers
  typedef struct packed {
    logic [COORD_W-1:0]       bot_x;
    logic [COORD_W-1:0]       bot_y;
    logic [COORD_W-1:0]       bot_z;
    logic signed [DIFF_W-1:0] axis_x;
    logic signed [DIFF_W-1:0] axis_y;
    logic signed [DIFF_W-1:0] axis_z;
    logic [LEN2_W-1:0]        len2;
    logic [LIMIT_W-1:0]       limit;
    logic                     degenerate;
    logic                     settled;
  } pic_geom_t;

  // sign-extend a coordinate by one bit for differences
  function automatic logic signed [DIFF_W-1:0] sx_diff(input logic [COORD_W-1:0] v);
    return {v[COORD_W-1], v};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pic_cfg.sv -----
// register file and derived cylinder geometry for the point-in-cylinder block
`default_nettype none

module pic_cfg import pic_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready,
  output pic_geom_t              geom_o
);

  logic [COORD_W-1:0] bot_q [3];
  logic [COORD_W-1:0] top_q [3];
  logic [RAD_W-1:0]   rad_q;

  logic                     wr_en;
  pic_reg_e                 reg_idx;

  logic signed [DIFF_W-1:0] axis_q [3];
  logic [RAD2_W-1:0]        rad2_q;
  logic [PROD_W-1:0]        asq_q [3];
  logic                     deg_q;
  logic [LEN2_W-1:0]        len2_q;
  logic [LPP_W-1:0]         lpp_q [4];
  logic [LIMIT_W-1:0]       limit_q;
  logic [SETTLE_W-1:0]      settle_q;
  logic [SETTLE_W-1:0]      settle_d;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = pic_reg_e'(paddr[APB_AW-1:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bot_q[0] <= '0;
      bot_q[1] <= '0;
      bot_q[2] <= '0;
      top_q[0] <= '0;
      top_q[1] <= '0;
      top_q[2] <= TOP_Z_RESET;
      rad_q    <= RAD_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BOTTOM_X: bot_q[0] <= pwdata[COORD_W-1:0];
        REG_BOTTOM_Y: bot_q[1] <= pwdata[COORD_W-1:0];
        REG_BOTTOM_Z: bot_q[2] <= pwdata[COORD_W-1:0];
        REG_TOP_X:    top_q[0] <= pwdata[COORD_W-1:0];
        REG_TOP_Y:    top_q[1] <= pwdata[COORD_W-1:0];
        REG_TOP_Z:    top_q[2] <= pwdata[COORD_W-1:0];
        REG_RADIUS:   rad_q    <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_BOTTOM_X: prdata = APB_DW'(bot_q[0]);
      REG_BOTTOM_Y: prdata = APB_DW'(bot_q[1]);
      REG_BOTTOM_Z: prdata = APB_DW'(bot_q[2]);
      REG_TOP_X:    prdata = APB_DW'(top_q[0]);
      REG_TOP_Y:    prdata = APB_DW'(top_q[1]);
      REG_TOP_Z:    prdata = APB_DW'(top_q[2]);
      REG_RADIUS:   prdata = APB_DW'(rad_q);
      default:      prdata = '0;
    endcase
  end

  // geometry chain: axis and radius squared
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      axis_q[k] <= sx_diff(top_q[k]) - sx_diff(bot_q[k]);
    end
    rad2_q <= rad_q * rad_q;
  end

  // squared axis components and zero-length check
  always_ff @(posedge clk_i) begin
    logic signed [PROD_W-1:0] sq;
    for (int k = 0; k < 3; k++) begin
      sq       = axis_q[k] * axis_q[k];
      asq_q[k] <= sq;
    end
    deg_q <= (axis_q[0] == '0) && (axis_q[1] == '0) && (axis_q[2] == '0);
  end

  // squared axis length
  always_ff @(posedge clk_i) begin
    len2_q <= asq_q[0] + asq_q[1] + asq_q[2];
  end

  // radius squared times squared length, split into partial products
  always_ff @(posedge clk_i) begin
    lpp_q[0] <= rad2_q[RAD_W-1:0]      * len2_q[LEN2_HALF-1:0];
    lpp_q[1] <= rad2_q[RAD_W-1:0]      * len2_q[LEN2_W-1:LEN2_HALF];
    lpp_q[2] <= rad2_q[RAD2_W-1:RAD_W] * len2_q[LEN2_HALF-1:0];
    lpp_q[3] <= rad2_q[RAD2_W-1:RAD_W] * len2_q[LEN2_W-1:LEN2_HALF];
  end

  // recombine partial products
  always_ff @(posedge clk_i) begin
    limit_q <= LIMIT_W'(lpp_q[0])
             + (LIMIT_W'(lpp_q[1]) << LEN2_HALF)
             + (LIMIT_W'(lpp_q[2]) << RAD_W)
             + (LIMIT_W'(lpp_q[3]) << (RAD_W + LEN2_HALF));
  end

  // settle counter after reset
  always_comb begin
    settle_d = settle_q;
    if (settle_q != SETTLE_W'(SETTLE_CYC)) begin
      settle_d = settle_q + SETTLE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= '0;
    end else begin
      settle_q <= settle_d;
    end
  end

  assign geom_o.bot_x      = bot_q[0];
  assign geom_o.bot_y      = bot_q[1];
  assign geom_o.bot_z      = bot_q[2];
  assign geom_o.axis_x     = axis_q[0];
  assign geom_o.axis_y     = axis_q[1];
  assign geom_o.axis_z     = axis_q[2];
  assign geom_o.len2       = len2_q;
  assign geom_o.limit      = limit_q;
  assign geom_o.degenerate = deg_q;
  assign geom_o.settled    = (settle_q == SETTLE_W'(SETTLE_CYC));

endmodule

`default_nettype wire

// ----- hw/rtl/point_in_cylinder_test.sv -----
// top level of the point-in-finite-cylinder test: item pipeline and checks
//
// channel  direction  handshake                 payload
// in       in         in_valid_i / in_stall_o   pic_in_t  (point_x, point_y, point_z)
// out      out        out_valid_o / out_stall_i pic_out_t (is_inside, axis_degenerate)
// cfg      in         psel / penable / pwrite   seven geometry registers
//
// one request per cycle whenever in_stall_o is low; each result passes the whole stage
// pipeline, whose depth is set by the two-level split of the squares of the 42-bit cross magnitudes
// after reset the input stalls while the derived geometry settles
// the derived geometry follows a register write through its register chain, with no input stall
// a stalled result freezes the whole pipeline and the input stall follows it
`default_nettype none
`include "point_in_cylinder_test_defines.svh"

module point_in_cylinder_test import pic_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pic_in_t           in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pic_out_t               out_req_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  pic_geom_t geom;

  logic              adv;
  logic              accept;
  logic [STG_N-1:0]  vld_q;

  logic signed [DIFF_W-1:0]  t_q [3];
  logic signed [PROD_W-1:0]  dp_q [3];
  logic signed [PROD_W-1:0]  cpp_q [3];
  logic signed [PROD_W-1:0]  cpn_q [3];
  logic signed [DOT_W-1:0]   h_q;
  logic signed [CROSS_W-1:0] c_q [3];
  logic                      axial4_q;
  logic [MAG_W-1:0]          mag_q [3];
  logic                      axial5_q;
  logic [MAG_W-1:0]          pll_q [3];
  logic [MAG_W-1:0]          plh_q [3];
  logic [MAG_W-1:0]          phh_q [3];
  logic                      axial6_q;
  logic [SQ_W-1:0]           sq_q [3];
  logic                      axial7_q;
  logic [AREA_W-1:0]         area_q;
  pic_out_t                  out_q;

  pic_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom_o  (geom)
  );

  // handshake and valid bits
  assign adv        = !(vld_q[STG_N-1] && out_stall_i);
  assign in_stall_o = !geom.settled || !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[STG_N-2:0], accept};
    end
  end

  // stage 1: point relative to the bottom end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q[0] <= sx_diff(in_req_i.point_x) - sx_diff(geom.bot_x);
      t_q[1] <= sx_diff(in_req_i.point_y) - sx_diff(geom.bot_y);
      t_q[2] <= sx_diff(in_req_i.point_z) - sx_diff(geom.bot_z);
    end
  end

  // stage 2: dot and cross product terms
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dp_q[0]  <= geom.axis_x * t_q[0];
      dp_q[1]  <= geom.axis_y * t_q[1];
      dp_q[2]  <= geom.axis_z * t_q[2];
      cpp_q[0] <= geom.axis_y * t_q[2];
      cpn_q[0] <= geom.axis_z * t_q[1];
      cpp_q[1] <= geom.axis_z * t_q[0];
      cpn_q[1] <= geom.axis_x * t_q[2];
      cpp_q[2] <= geom.axis_x * t_q[1];
      cpn_q[2] <= geom.axis_y * t_q[0];
    end
  end

  // stage 3: axial projection and cross product components
  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_q <= DOT_W'(dp_q[0]) + DOT_W'(dp_q[1]) + DOT_W'(dp_q[2]);
      for (int k = 0; k < 3; k++) begin
        c_q[k] <= CROSS_W'(cpp_q[k]) - CROSS_W'(cpn_q[k]);
      end
    end
  end

  // stage 4: axial range check and cross component magnitudes
  always_ff @(posedge clk_i) begin
    logic signed [CROSS_W-1:0] neg;
    if (adv) begin
      axial4_q <= !h_q[DOT_W-1] && (h_q <= $signed({2'b00, geom.len2}));
      for (int k = 0; k < 3; k++) begin
        neg = -c_q[k];
        mag_q[k] <= c_q[k][CROSS_W-1] ? neg[MAG_W-1:0] : c_q[k][MAG_W-1:0];
      end
    end
  end

  // stage 5: partial products of each square
  always_ff @(posedge clk_i) begin
    if (adv) begin
      axial5_q <= axial4_q;
      for (int k = 0; k < 3; k++) begin
        pll_q[k] <= mag_q[k][HALF_W-1:0]     * mag_q[k][HALF_W-1:0];
        plh_q[k] <= mag_q[k][HALF_W-1:0]     * mag_q[k][MAG_W-1:HALF_W];
        phh_q[k] <= mag_q[k][MAG_W-1:HALF_W] * mag_q[k][MAG_W-1:HALF_W];
      end
    end
  end

  // stage 6: recombine squares
  always_ff @(posedge clk_i) begin
    if (adv) begin
      axial6_q <= axial5_q;
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= (SQ_W'(phh_q[k]) << MAG_W)
                 + (SQ_W'(plh_q[k]) << (HALF_W + 1))
                 + SQ_W'(pll_q[k]);
      end
    end
  end

  // stage 7: squared cross norm
  always_ff @(posedge clk_i) begin
    if (adv) begin
      axial7_q <= axial6_q;
      area_q   <= AREA_W'(sq_q[0]) + AREA_W'(sq_q[1]) + AREA_W'(sq_q[2]);
    end
  end

  // stage 8: radial check into the output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.axis_degenerate <= geom.degenerate;
      out_q.is_inside       <= !geom.degenerate && axial7_q
                               && (area_q <= AREA_W'(geom.limit));
    end
  end

  assign out_valid_o = vld_q[STG_N-1];
  assign out_req_o   = out_q;

  // checks
  `PIC_ASSERT_IMPL(a_deg_outside, clk_i, rst_ni, out_valid_o && out_req_o.axis_degenerate, !out_req_o.is_inside, "degenerate axis reported inside")
  `PIC_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, accept, vld_q[0], "accepted request missing from first stage")
  `PIC_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, vld_q[STG_N-1] && out_stall_i, $stable(vld_q), "pipeline moved during output stall")

endmodule

`default_nettype wire

// ----- tb/tb_point_in_cylinder_test.sv -----
// testbench for the point-in-cylinder block: register setup, point stream, result checks
`timescale 1ns / 1ps

module tb_point_in_cylinder_test;
  import pic_pkg::*;

  localparam int      WIDE_W      = 128;
  localparam int      CYCLE_LIMIT = 600000;
  localparam int      REG_NONE    = REG_N;     // first index past the register file
  localparam longint  COORD_MIN   = -(longint'(1) <<< (COORD_W - 1));
  localparam longint  COORD_MAX   = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam int      HOLD_CYC    = 400;

  typedef enum int {
    GEOM_WIDE,
    GEOM_SMALL,
    GEOM_ALIGNED,
    GEOM_BIG_RADIUS
  } geom_style_e;

  // one accepted point and the answer it must produce
  typedef struct {
    pic_in_t  pt;
    pic_out_t res;
  } containment_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  pic_in_t           in_req_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  pic_out_t          out_req_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // shadow of the geometry registers
  logic [COORD_W-1:0] cyl_bot [3];
  logic [COORD_W-1:0] cyl_top [3];
  logic [RAD_W-1:0]   cyl_radius;

  containment_t containment_q [$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  int  rx_hold_req = 0;
  int  rx_hold_left = 0;
  int  rx_wait = 0;

  point_in_cylinder_test u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // exact containment test on the raw fixed-point values
  function automatic pic_out_t predict_containment(input pic_in_t pt);
    logic signed [WIDE_W-1:0]  a [3];
    logic signed [WIDE_W-1:0]  t [3];
    logic signed [COORD_W-1:0] p [3];
    logic signed [WIDE_W-1:0]  along, len2, cx, cy, cz, area, lim, rad;
    pic_out_t res;
    p[0] = pt.point_x;
    p[1] = pt.point_y;
    p[2] = pt.point_z;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(cyl_top[i]) - $signed(cyl_bot[i]);
      t[i] = p[i] - $signed(cyl_bot[i]);
    end
    rad = $signed({1'b0, cyl_radius});
    along = a[0] * t[0] + a[1] * t[1] + a[2] * t[2];
    len2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    cx = a[1] * t[2] - a[2] * t[1];
    cy = a[2] * t[0] - a[0] * t[2];
    cz = a[0] * t[1] - a[1] * t[0];
    area = cx * cx + cy * cy + cz * cz;
    lim = rad * rad * len2;
    res.axis_degenerate = (a[0] == 0) && (a[1] == 0) && (a[2] == 0);
    res.is_inside = !res.axis_degenerate && (along >= 0) && (along <= len2) && (area <= lim);
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    containment_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (containment_q.size() == 0) begin
        report_mismatch($sformatf("result %b with no request pending", out_req_o));
      end else begin
        want = containment_q.pop_front();
        if (out_req_o.is_inside !== want.res.is_inside)
          report_mismatch($sformatf("is_inside %b, want %b, point %0d %0d %0d",
                          out_req_o.is_inside, want.res.is_inside,
                          want.pt.point_x, want.pt.point_y, want.pt.point_z));
        if (out_req_o.axis_degenerate !== want.res.axis_degenerate)
          report_mismatch($sformatf("axis_degenerate %b, want %b, point %0d %0d %0d",
                          out_req_o.axis_degenerate, want.res.axis_degenerate,
                          want.pt.point_x, want.pt.point_y, want.pt.point_z));
      end
    end
  end

  // receiver stall: a random wait after each result while rx_idle is set, plus a long hold on request
  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (out_valid_o && !out_stall_i) rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
    else if (rx_wait != 0) rx_wait--;
    if (rx_hold_left != 0) rx_hold_left--;
    out_stall_i <= (rx_wait != 0) || (rx_hold_left != 0);
  end

  // one request on the point channel
  task automatic send_point(input pic_in_t pt);
    int gap;
    containment_t entry;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= pt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    entry.pt = pt;
    entry.res = predict_containment(pt);
    containment_q.push_back(entry);
  endtask

  task automatic send_xyz(input int x, input int y, input int z);
    pic_in_t pt;
    pt.point_x = COORD_W'(x);
    pt.point_y = COORD_W'(y);
    pt.point_z = COORD_W'(z);
    send_point(pt);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (containment_q.size() != 0);
  endtask

  function automatic pic_in_t any_point();
    pic_in_t pt;
    pt = {COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom())};
    return pt;
  endfunction

  // point scattered around the axis segment, a bit past both ends
  function automatic pic_in_t near_point();
    longint base, axis, off, span, pos;
    logic [COORD_W-1:0] c [3];
    int step;
    step = $urandom_range(0, 1400);
    span = longint'(cyl_radius) + longint'(cyl_radius) / 2 + 2;
    for (int i = 0; i < 3; i++) begin
      base = longint'($signed(cyl_bot[i]));
      axis = longint'($signed(cyl_top[i])) - base;
      off = longint'($urandom_range(0, 2 * span)) - span;
      pos = base + axis * (step - 200) / 1000 + off;
      if (pos < COORD_MIN) pos = COORD_MIN;
      if (pos > COORD_MAX) pos = COORD_MAX;
      c[i] = COORD_W'(pos);
    end
    return pic_in_t'({c[0], c[1], c[2]});
  endfunction

  function automatic logic [APB_DW-1:0] reg_mask(input int idx);
    if (idx == REG_RADIUS) return APB_DW'((1 << RAD_W) - 1);
    return APB_DW'((1 << COORD_W) - 1);
  endfunction

  function automatic logic [APB_DW-1:0] register_value(input int idx);
    if (idx == REG_RADIUS) return APB_DW'(cyl_radius);
    if (idx >= REG_TOP_X) return APB_DW'(cyl_top[idx - REG_TOP_X]);
    return APB_DW'(cyl_bot[idx]);
  endfunction

  // setup and access phase; psel stays up for a following transfer
  task automatic apb_transfer(input logic wr, input int idx, input logic [APB_DW-1:0] data,
                              output logic [APB_DW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= APB_AW'(idx * 4);
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
  endtask

  task automatic check_register(input int idx);
    logic [APB_DW-1:0] rd;
    apb_transfer(1'b0, idx, '0, rd);
    if ((rd & reg_mask(idx)) != register_value(idx))
      report_mismatch($sformatf("register %0d reads %h, want %h", idx,
                      rd & reg_mask(idx), register_value(idx)));
  endtask

  // write with junk above the field, then read it back if it is in the register file
  task automatic write_register(input int idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] junk, data, rd;
    junk = $urandom();
    data = (value & reg_mask(idx)) | (junk & ~reg_mask(idx));
    apb_transfer(1'b1, idx, data, rd);
    if (idx == REG_RADIUS) cyl_radius = data[RAD_W-1:0];
    else if (idx >= REG_TOP_X && idx <= REG_TOP_Z) cyl_top[idx - REG_TOP_X] = data[COORD_W-1:0];
    else if (idx <= REG_BOTTOM_Z) cyl_bot[idx] = data[COORD_W-1:0];
    if (idx < REG_N) check_register(idx);
  endtask

  // release the bus and let the derived geometry follow the registers
  task automatic settle_geometry();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    repeat (SETTLE_CYC + 3) @(posedge clk_i);
  endtask

  task automatic write_geometry(input int bx, input int by, input int bz,
                                input int tx, input int ty, input int tz, input int r);
    write_register(REG_BOTTOM_X, APB_DW'(bx));
    write_register(REG_BOTTOM_Y, APB_DW'(by));
    write_register(REG_BOTTOM_Z, APB_DW'(bz));
    write_register(REG_TOP_X, APB_DW'(tx));
    write_register(REG_TOP_Y, APB_DW'(ty));
    write_register(REG_TOP_Z, APB_DW'(tz));
    write_register(REG_RADIUS, APB_DW'(r));
    settle_geometry();
  endtask

  function automatic int rand_coord(input int span);
    if (span == 0) return int'($signed(COORD_W'($urandom())));
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic random_geometry(input geom_style_e style);
    int b [3];
    int t [3];
    int r, k, d;
    for (int i = 0; i < 3; i++) begin
      b[i] = rand_coord(style == GEOM_SMALL ? 4096 : style == GEOM_ALIGNED ? 20000 : 0);
      t[i] = rand_coord(style == GEOM_SMALL ? 4096 : 0);
    end
    case (style)
      GEOM_WIDE: begin
        r = $urandom_range(0, (1 << RAD_W) - 1);
      end
      GEOM_SMALL: begin
        r = $urandom_range(0, 3000);
      end
      GEOM_ALIGNED: begin
        k = $urandom_range(0, 2);
        d = $urandom_range(1, 40000);
        if ($urandom_range(0, 1) != 0) d = -d;
        t = b;
        t[k] = b[k] + d;
        r = $urandom_range(1, 20000);
      end
      default: begin
        r = $urandom_range(1 << 16, (1 << RAD_W) - 1);
      end
    endcase
    write_geometry(b[0], b[1], b[2], t[0], t[1], t[2], r);
  endtask

  // reset values, then points on and just off the default cylinder
  task automatic test_reset_geometry();
    for (int i = 0; i < REG_N; i++) check_register(i);
    settle_geometry();
    send_xyz(0, 0, 0);
    send_xyz(0, 0, 256);
    send_xyz(0, 0, -1);
    send_xyz(0, 0, 257);
    send_xyz(256, 0, 128);
    send_xyz(257, 0, 128);
    send_xyz(181, 181, 10);
    send_xyz(182, 181, 10);
    send_xyz(int'(COORD_MIN), int'(COORD_MIN), int'(COORD_MIN));
    send_xyz(int'(COORD_MAX), int'(COORD_MAX), int'(COORD_MAX));
    drain_results();
  endtask

  // top equal to bottom
  task automatic test_degenerate_axis();
    int bx, by, bz;
    bx = rand_coord(0);
    by = rand_coord(0);
    bz = rand_coord(0);
    write_geometry(bx, by, bz, bx, by, bz, $urandom_range(1, 5000));
    send_xyz(bx, by, bz);
    send_point(any_point());
    send_xyz(bx + 1, by, bz);
    drain_results();
  endtask

  // only the axis segment itself is inside
  task automatic test_zero_radius();
    write_geometry(0, 0, 0, 1024, 512, -256, 0);
    send_xyz(0, 0, 0);
    send_xyz(512, 256, -128);
    send_xyz(1024, 512, -256);
    send_xyz(513, 256, -128);
    send_xyz(2048, 1024, -512);
    drain_results();
  endtask

  // corner-to-corner axis, largest radius, and a write past the register file
  task automatic test_extreme_geometry();
    int lo, hi;
    lo = int'(COORD_MIN);
    hi = int'(COORD_MAX);
    write_geometry(lo, lo, lo, hi, hi, hi, (1 << RAD_W) - 1);
    send_xyz(lo, lo, lo);
    send_xyz(hi, hi, hi);
    send_xyz(0, 0, 0);
    send_xyz(hi, lo, 0);
    send_xyz(lo, hi, hi);
    drain_results();
    write_geometry(hi, hi, hi, lo, lo, lo, 1);
    send_xyz(hi, hi, hi);
    send_xyz(0, 0, 0);
    drain_results();
    write_register(REG_NONE, $urandom());
    settle_geometry();
    send_xyz(-1, -1, -1);
    drain_results();
  endtask

  // phases of random cylinders, mostly with points around the axis
  task automatic test_random_cylinders();
    for (int ph = 0; ph < 7; ph++) begin
      random_geometry(geom_style_e'(ph % 4));
      tx_idle = (ph % 3) != 1;
      rx_idle = (ph % 3) == 0;
      for (int n = 0; n < 240; n++) begin
        if ($urandom_range(0, 4) == 0) send_point(any_point());
        else send_point(near_point());
      end
      drain_results();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // receiver holds off while points keep coming, so the input stalls
  task automatic test_output_backpressure();
    random_geometry(GEOM_SMALL);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_req = HOLD_CYC;
    for (int n = 0; n < 48; n++) send_point(near_point());
    drain_results();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    cyl_bot = '{'0, '0, '0};
    cyl_top = '{'0, '0, TOP_Z_RESET};
    cyl_radius = RAD_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_geometry();
    test_degenerate_axis();
    test_zero_radius();
    test_extreme_geometry();
    test_random_cylinders();
    test_output_backpressure();
    repeat (2 * STG_N) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/pic_pkg.sv
hw/rtl/pic_cfg.sv
hw/rtl/point_in_cylinder_test.sv
tb/tb_point_in_cylinder_test.sv
